// ===== design/sbhv_pkg.sv =====
// Shared types, constants and the CRC-32 byte step for the state blob header validator.
`timescale 1ns / 1ps

package sbhv_pkg;

  localparam int unsigned POS_W             = 28;
  localparam int unsigned MAX_SECTION_BYTES = 64 * 1024 * 1024;

  // Header layout, byte offsets from the start of the blob
  localparam int unsigned OFF_VER   = 8;
  localparam int unsigned OFF_CLS   = 12;
  localparam int unsigned OFF_LEN1  = 28;
  localparam int unsigned OFF_LEN2  = 36;
  localparam int unsigned OFF_CHK   = 44;
  localparam int unsigned HDR_BYTES = 48;

  localparam logic [31:0] VERSION_OK = 32'd1;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

  localparam logic [7:0] MAGIC [8] = '{8'h4D, 8'h56, 8'h4D, 8'h53, 8'h56, 8'h53, 8'h54, 8'h33};

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    KIND_MAGIC   = 3'd0,
    KIND_HDR_NUM = 3'd1,
    KIND_CLASS   = 3'd2,
    KIND_SECT1   = 3'd3,
    KIND_SECT2   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HDR   = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_CRC_ERR   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       done;
    status_e    status;
  } res_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== design/sbhv_parse.sv =====
// Header field capture, byte tagging, payload CRC and final status for one blob.
`timescale 1ns / 1ps

module sbhv_parse #(
  parameter int unsigned MaxSectionBytes = sbhv_pkg::MAX_SECTION_BYTES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [7:0]       data_i,
  input  logic             last_i,
  output sbhv_pkg::res_t   res_o
);

  localparam logic [63:0] MaxLen = 64'(MaxSectionBytes);
  localparam int unsigned CntW   = sbhv_pkg::POS_W + 1;

  sbhv_pkg::pos_t pos_q;
  logic           magic_ok_q;
  logic [31:0]    version_q;
  logic [63:0]    len1_q, len2_q;
  logic [31:0]    exp_chk_q, exp_chk_d;
  logic [31:0]    crc_q, crc_d;

  logic           saturated;
  logic           in_magic, in_ver, in_cls, in_len1, in_len2, in_chk, in_pay;
  logic [2:0]     lane8;
  logic [1:0]     lane4;
  sbhv_pkg::pos_t pay_off;
  logic [CntW-1:0] count;
  logic [63:0]    len_sum;
  logic [63:0]    pay_len;
  sbhv_pkg::kind_e   kind;
  sbhv_pkg::status_e status;

  assign saturated = &pos_q;
  assign in_magic  = pos_q < sbhv_pkg::POS_W'(sbhv_pkg::OFF_VER);
  assign in_ver    = !in_magic && pos_q < sbhv_pkg::POS_W'(sbhv_pkg::OFF_CLS);
  assign in_cls    = pos_q >= sbhv_pkg::POS_W'(sbhv_pkg::OFF_CLS)
                  && pos_q < sbhv_pkg::POS_W'(sbhv_pkg::OFF_LEN1);
  assign in_len1   = pos_q >= sbhv_pkg::POS_W'(sbhv_pkg::OFF_LEN1)
                  && pos_q < sbhv_pkg::POS_W'(sbhv_pkg::OFF_LEN2);
  assign in_len2   = pos_q >= sbhv_pkg::POS_W'(sbhv_pkg::OFF_LEN2)
                  && pos_q < sbhv_pkg::POS_W'(sbhv_pkg::OFF_CHK);
  assign in_chk    = pos_q >= sbhv_pkg::POS_W'(sbhv_pkg::OFF_CHK)
                  && pos_q < sbhv_pkg::POS_W'(sbhv_pkg::HDR_BYTES);
  assign in_pay    = pos_q >= sbhv_pkg::POS_W'(sbhv_pkg::HDR_BYTES);

  // Lane of the current byte inside its little-endian field
  assign lane8 = 3'(pos_q[2:0] - 3'(sbhv_pkg::OFF_LEN1));
  assign lane4 = 2'(pos_q[1:0] - 2'(sbhv_pkg::OFF_CHK));

  assign pay_off = pos_q - sbhv_pkg::POS_W'(sbhv_pkg::HDR_BYTES);

  // The last header byte and the last payload byte count in the final check
  always_comb begin
    exp_chk_d = exp_chk_q;
    if (in_chk) exp_chk_d[8*lane4 +: 8] = data_i;
  end
  assign crc_d = in_pay ? sbhv_pkg::crc32_byte(crc_q, data_i) : crc_q;

  always_comb begin
    kind = sbhv_pkg::KIND_HDR_NUM;
    if (in_magic)    kind = sbhv_pkg::KIND_MAGIC;
    else if (in_cls) kind = sbhv_pkg::KIND_CLASS;
    else if (in_pay) kind = ({36'b0, pay_off} < len1_q) ? sbhv_pkg::KIND_SECT1
                                                         : sbhv_pkg::KIND_SECT2;
  end

  assign count   = {1'b0, pos_q} + CntW'(1);
  assign len_sum = len1_q + len2_q;
  assign pay_len = 64'(count - CntW'(sbhv_pkg::HDR_BYTES));

  always_comb begin
    status = sbhv_pkg::ST_OK;
    if (count < CntW'(sbhv_pkg::HDR_BYTES) || !magic_ok_q) begin
      status = sbhv_pkg::ST_BAD_HDR;
    end else if (version_q != sbhv_pkg::VERSION_OK) begin
      status = sbhv_pkg::ST_BAD_VER;
    end else if (saturated || len1_q > MaxLen || len2_q > MaxLen || len_sum != pay_len) begin
      status = sbhv_pkg::ST_BAD_LEN;
    end else if (~crc_d != exp_chk_d) begin
      status = sbhv_pkg::ST_CRC_ERR;
    end
    if (!last_i) status = sbhv_pkg::ST_OK;
  end

  assign res_o = '{data: data_i, kind: kind, done: last_i, status: status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      magic_ok_q <= 1'b1;
      version_q  <= '0;
      len1_q     <= '0;
      len2_q     <= '0;
      exp_chk_q  <= '0;
      crc_q      <= sbhv_pkg::CRC_INIT;
    end else if (adv_i) begin
      if (last_i) begin
        // back to the start of a new blob
        pos_q      <= '0;
        magic_ok_q <= 1'b1;
        version_q  <= '0;
        len1_q     <= '0;
        len2_q     <= '0;
        exp_chk_q  <= '0;
        crc_q      <= sbhv_pkg::CRC_INIT;
      end else begin
        if (!saturated) pos_q <= pos_q + sbhv_pkg::POS_W'(1);
        if (in_magic && data_i != sbhv_pkg::MAGIC[pos_q[2:0]]) magic_ok_q <= 1'b0;
        if (in_ver)  version_q[8*pos_q[1:0] +: 8] <= data_i;
        if (in_len1) len1_q[8*lane8 +: 8] <= data_i;
        if (in_len2) len2_q[8*lane8 +: 8] <= data_i;
        exp_chk_q <= exp_chk_d;
        crc_q     <= crc_d;
      end
    end
  end

endmodule

// ===== design/state_blob_header_validator_core.sv =====
// Top level of the state blob header validator: request handshakes and result register.
`timescale 1ns / 1ps

// Takes one blob byte per request and returns one result per byte: the byte, its kind
// (magic, header number, class id, first or second section) and, on the byte flagged
// last, the blob status. Throughput is one byte per cycle; a result appears in the
// output register the cycle after its request is taken. The single output register
// sets the rate: input is stalled only while a held result is itself stalled.
// After the last byte the block is back at the start of a new blob at once.
module state_blob_header_validator_core #(
  parameter int unsigned MaxSectionBytes = sbhv_pkg::MAX_SECTION_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] byte_kind_o,
  output logic       done_res_o,
  output logic [2:0] status_o
);

  logic           accept;
  logic           out_valid_q;
  sbhv_pkg::res_t res_d, res_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  sbhv_parse #(
    .MaxSectionBytes(MaxSectionBytes)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (accept),
    .data_i (data_byte_i),
    .last_i (last_byte_i),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = res_q.data;
  assign byte_kind_o = res_q.kind;
  assign done_res_o  = res_q.done;
  assign status_o    = res_q.status;

endmodule

// ===== design/sbhv_checker.sv =====
// Port-level checks for the state blob header validator, bound to the top level.
`timescale 1ns / 1ps

module sbhv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] data_byte_i,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic [2:0] byte_kind_o,
  input logic       done_res_o,
  input logic [2:0] status_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(byte_kind_o) && $stable(done_res_o) && $stable(status_o))
    else $error("stalled result changed");

  // input is only held off by a stalled pending result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without held result");

  // every request yields a result in the next cycle carrying its byte
  a_req_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o && out_byte_o == $past(data_byte_i)
      && done_res_o == $past(last_byte_i))
    else $error("request result missing or wrong");

  // status is only reported on the final byte
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == sbhv_pkg::ST_OK)
    else $error("status set on non-final byte");

endmodule

bind state_blob_header_validator_core sbhv_checker u_sbhv_checker (.*);
